// ===== rtl/tcw_pkg.sv =====
// shared types and constants for the text console character writer
// no dependencies; imported by the controller and the top level
`default_nettype none

package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;
    localparam int IDX_W  = 11;
    localparam int CHR_W  = 8;
    localparam int CELL_W = 16;

    // request kinds
    localparam logic [1:0] REQ_PUT     = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_SAVE    = 2'd2;
    localparam logic [1:0] REQ_RESTORE = 2'd3;

    // control characters and fill values
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_BS     = 8'h08;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_NL     = 8'h0A;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // register index, taken from paddr[2]
    localparam logic REG_DEFAULT_ATTR = 1'b0;
    localparam logic REG_CURSOR_EN    = 1'b1;

    typedef struct packed {
        logic [7:0] default_attr;
        logic       cursor_update_enable;
    } tcw_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_screen_ram.sv =====
// screen cell memory: one write port, one read port, registered read data
// no dependencies
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
// request sequencer: cursor state, cell writes, scroll sweep, clearing pass, result register
// depends on tcw_pkg; drives the ports of tcw_screen_ram
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4,
    localparam int CELLS     = COLUMNS * ROWS,
    localparam int AW        = $clog2(CELLS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcw_cfg_t            cfg,
    // request side
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          req_type,
    input  wire logic [CHR_W-1:0]    char_code,
    input  wire logic [CHR_W-1:0]    attr,
    input  wire logic                use_default_attr,
    input  wire logic [IDX_W-1:0]    cell_index,
    // result side
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COL_W-1:0]         cursor_col,
    output logic [ROW_W-1:0]         cursor_line,
    output logic [LIN_W-1:0]         cursor_linear,
    output logic                     cursor_write,
    output logic [CELL_W-1:0]        read_data,
    // screen memory
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [CELL_W-1:0]        wr_data,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  wire logic [CELL_W-1:0]   rd_data
);

    localparam int TW = $clog2(TAB_SPACES + 1);
    localparam logic [AW-1:0]    LAST_A  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]    END_A   = AW'(CELLS - 1);
    localparam logic [AW-1:0]    COL_A   = AW'(COLUMNS);
    localparam logic [7:0]       COL_LIM = 8'(COLUMNS);
    localparam logic [5:0]       ROW_LIM = 6'(ROWS);
    localparam logic [ROW_W-1:0] ROW_BOT = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  scol_reg, scol_next;
    logic [ROW_W-1:0]  srow_reg, srow_next;
    logic [1:0]        req_reg, req_next;
    logic [CHR_W-1:0]  ch_reg, ch_next;
    logic [CHR_W-1:0]  at_reg, at_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TW-1:0]     tab_reg, tab_next;
    logic [AW-1:0]     scan_reg, scan_next;
    logic              wv_reg, wv_next;
    logic              wclr_reg, wclr_next;
    logic [AW-1:0]     waddr_reg, waddr_next;
    logic              hit_reg, hit_next;
    logic              ov_reg, ov_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [LIN_W-1:0]  olin_reg, olin_next;
    logic              owr_reg, owr_next;
    logic [CELL_W-1:0] ord_reg, ord_next;

    logic [AW-1:0] cur_addr;
    logic [7:0]    col_inc;
    logic [5:0]    row_inc;
    logic          col_wrap;
    logic          row_over;
    logic          idx_hit;

    assign cur_addr = AW'(row_reg) * COL_A + AW'(col_reg);
    assign col_inc  = 8'(col_reg) + 8'd1;
    assign row_inc  = 6'(row_reg) + 6'd1;
    assign col_wrap = col_inc >= COL_LIM;
    assign row_over = row_inc >= ROW_LIM;
    assign idx_hit  = 32'(idx_reg) < 32'(CELLS);

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        scol_next  = scol_reg;
        srow_next  = srow_reg;
        req_next   = req_reg;
        ch_next    = ch_reg;
        at_next    = at_reg;
        idx_next   = idx_reg;
        tab_next   = tab_reg;
        scan_next  = scan_reg;
        wv_next    = 1'b0;
        wclr_next  = wclr_reg;
        waddr_next = waddr_reg;
        hit_next   = hit_reg;
        ov_next    = ov_reg && !out_ready;
        ocol_next  = ocol_reg;
        orow_next  = orow_reg;
        olin_next  = olin_reg;
        owr_next   = owr_reg;
        ord_next   = ord_reg;
        wr_en      = 1'b0;
        wr_addr    = cur_addr;
        wr_data    = {cfg.default_attr, CHR_SPACE};
        rd_en      = 1'b0;
        rd_addr    = AW'(idx_reg);

        // trailing write of the scroll sweep
        if (wv_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = waddr_reg;
            wr_data = wclr_reg ? {cfg.default_attr, CHR_NUL} : rd_data;
        end

        case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = scan_reg;
                wr_data = {ATTR_RESET, CHR_NUL};
                if (scan_reg == END_A)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    ch_next    = char_code;
                    at_next    = use_default_attr ? cfg.default_attr : attr;
                    idx_next   = cell_index;
                    tab_next   = TW'(TAB_SPACES);
                    hit_next   = 1'b0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (req_reg)
                    REQ_PUT:
                    begin
                        case (ch_reg)
                            CHR_NL:
                            begin
                                col_next = '0;
                                row_next = row_inc[ROW_W-1:0];
                                if (row_over)
                                begin
                                    row_next   = ROW_BOT;
                                    scan_next  = COL_A;
                                    state_next = ST_SCROLL;
                                end
                            end
                            CHR_BS:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - COL_W'(1);
                                    wr_en    = 1'b1;
                                    wr_addr  = cur_addr - AW'(1);
                                end
                            end
                            default:
                            begin
                                wr_en = 1'b1;
                                if (ch_reg != CHR_TAB)
                                begin
                                    wr_data = {at_reg, ch_reg};
                                end
                                col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
                                if (col_wrap)
                                begin
                                    row_next = row_inc[ROW_W-1:0];
                                end
                                // a tab keeps cycling here until its spaces are out
                                if (ch_reg == CHR_TAB)
                                begin
                                    tab_next = tab_reg - TW'(1);
                                    if (tab_reg != TW'(1))
                                    begin
                                        state_next = ST_EXEC;
                                    end
                                end
                                if (col_wrap && row_over)
                                begin
                                    row_next   = ROW_BOT;
                                    scan_next  = COL_A;
                                    state_next = ST_SCROLL;
                                end
                            end
                        endcase
                    end
                    REQ_READ:
                    begin
                        hit_next = idx_hit;
                        rd_en    = idx_hit;
                    end
                    REQ_SAVE:
                    begin
                        scol_next = col_reg;
                        srow_next = row_reg;
                    end
                    default:
                    begin
                        col_next = scol_reg;
                        row_next = srow_reg;
                    end
                endcase
            end

            // read row r+1 while the cell read last cycle lands in row r
            ST_SCROLL:
            begin
                rd_en      = scan_reg < LAST_A;
                rd_addr    = scan_reg + COL_A;
                wv_next    = 1'b1;
                waddr_next = scan_reg;
                wclr_next  = scan_reg >= LAST_A;
                if (scan_reg == END_A)
                begin
                    state_next = ST_SCROLL_END;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end

            ST_SCROLL_END:
            begin
                state_next = (req_reg == REQ_PUT && ch_reg == CHR_TAB && tab_reg != '0)
                             ? ST_EXEC : ST_DONE;
            end

            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ocol_next  = col_reg;
                    orow_next  = row_reg;
                    olin_next  = LIN_W'(cur_addr);
                    owr_next   = cfg.cursor_update_enable;
                    ord_next   = hit_reg ? rd_data : '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            col_reg   <= '0;
            row_reg   <= ROW_W'(1);
            scol_reg  <= '0;
            srow_reg  <= '0;
            scan_reg  <= '0;
            tab_reg   <= '0;
            wv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            scol_reg  <= scol_next;
            srow_reg  <= srow_next;
            scan_reg  <= scan_next;
            tab_reg   <= tab_next;
            wv_reg    <= wv_next;
            hit_reg   <= hit_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        ch_reg    <= ch_next;
        at_reg    <= at_next;
        idx_reg   <= idx_next;
        wclr_reg  <= wclr_next;
        waddr_reg <= waddr_next;
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        olin_reg  <= olin_next;
        owr_reg   <= owr_next;
        ord_reg   <= ord_next;
    end

    assign out_valid     = ov_reg;
    assign cursor_col    = ocol_reg;
    assign cursor_line   = orow_reg;
    assign cursor_linear = olin_reg;
    assign cursor_write  = owr_reg;
    assign read_data     = ord_reg;

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer.sv =====
// a plain request passes the idle, execute and done states on its way to the result register;
// a tab stays in the execute state until its TAB_SPACES spaces are written, and a scroll adds
// a sweep of rows 1 to ROWS-1 and an end state; one request is in flight at a time
// reset: the cursor goes to column 0 row 1 and the screen memory is cleared to char 0,
// attribute 7, one cell per cycle, before the first request is taken
// top level: stream ports, config registers, controller and screen memory; depends on tcw_pkg
`default_nettype none

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // char_code, attr, cell_index, zero pad
    input  wire logic [2:0]  s_tuser,   // req_type, use_default_attr
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // cursor_col, cursor_line, cursor_linear, read_data, pad
    output logic [0:0]       m_tuser    // cursor_write
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    tcw_cfg_t cfg_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;

    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_line;
    logic [LIN_W-1:0]  cursor_linear;
    logic              cursor_write;
    logic [CELL_W-1:0] read_data;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_attr         <= ATTR_RESET;
            cfg_reg.cursor_update_enable <= 1'b1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_DEFAULT_ATTR: cfg_reg.default_attr <= pwdata[7:0];
                default:          cfg_reg.cursor_update_enable <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                REG_DEFAULT_ATTR: prdata = {24'd0, cfg_reg.default_attr};
                REG_CURSOR_EN:    prdata = {31'd0, cfg_reg.cursor_update_enable};
                default:          prdata = '0;
            endcase
        end
    end

    tcw_ctrl #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .req_type         (s_tuser[1:0]),
        .char_code        (s_tdata[7:0]),
        .attr             (s_tdata[15:8]),
        .use_default_attr (s_tuser[2]),
        .cell_index       (s_tdata[26:16]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .cursor_col       (cursor_col),
        .cursor_line      (cursor_line),
        .cursor_linear    (cursor_linear),
        .cursor_write     (cursor_write),
        .read_data        (read_data),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tdata = {1'b0, read_data, cursor_linear, cursor_line, cursor_col};
    assign m_tuser = cursor_write;

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// port-level checks for text_console_char_writer, attached by bind
// no package dependencies
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    logic [11:0] lin_exp;

    assign lin_exp = 12'(m_tdata[6:0]) + 12'(m_tdata[11:7]) * 12'(COLUMNS);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // cursor stays on the screen
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[6:0]) < COLUMNS) && (32'(m_tdata[11:7]) < ROWS))
        else $error("cursor off screen");

    // linear position agrees with column and row
    a_linear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[22:12] == lin_exp[10:0])
        else $error("cursor_linear mismatch");

    // one request at a time: input closes right after a request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

endmodule

bind text_console_char_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
